[sv/lds_pkg.sv]
// Shared types and defaults for the LOOK disk scheduler.
// No dependencies; lds_cmp, the top level and the testbench refer to it by scoped names.
`default_nettype none

package lds_pkg;

  localparam int unsigned MAX_REQUESTS_DEF = 16;
  localparam int unsigned TRACK_BITS_DEF   = 16;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned MOVE_W  = 17;
  localparam logic [MOVE_W-1:0] MOVE_MAX = 17'h1FFFF;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [FIELD_W-1:0] track;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] served_track;
    logic [MOVE_W-1:0]  total_movement;
    logic               last;
    logic               empty_run;
    logic               overflow;
  } res_t;

  // flags of the shared compare unit, a against b
  typedef struct packed {
    logic ge;
    logic gt;
  } cmp_flags_t;

endpackage

`default_nettype wire

[sv/lds_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module lds_ram #(
  parameter  int unsigned WIDTH = 16,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [AddrW-1:0]       waddr_i,
  input  wire logic [WIDTH-1:0]       wdata_i,
  input  wire logic [AddrW-1:0]       raddr_i,
  output logic      [WIDTH-1:0]       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[sv/lds_cmp.sv]
// Shared compare and distance unit: one subtractor gives a>=b, a>b and |a-b|.
// Depends on lds_pkg for the flag struct.
`default_nettype none

module lds_cmp #(
  parameter int unsigned W = 16
) (
  input  wire logic [W-1:0]     a_i,
  input  wire logic [W-1:0]     b_i,
  output lds_pkg::cmp_flags_t   flags_o,
  output logic      [W-1:0]     absdiff_o
);

  logic [W:0] diff;
  logic       borrow;

  assign diff      = {1'b0, a_i} - {1'b0, b_i};
  assign borrow    = diff[W];
  assign flags_o.ge = !borrow;
  assign flags_o.gt = !borrow && (diff[W-1:0] != '0);
  // negate the low bits when b is the larger operand
  assign absdiff_o = borrow ? (~diff[W-1:0] + {{(W-1){1'b0}}, 1'b1}) : diff[W-1:0];

endmodule

`default_nettype wire

[sv/look_disk_scheduler.sv]
// LOOK disk scheduler top level: sequencer, request RAM and shared compare unit.
// Depends on lds_pkg, lds_ram and lds_cmp.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// request   in         start && !busy            req_i   (lds_pkg::req_t)
// result    out        res_strobe_o, one cycle   res_o   (lds_pkg::res_t)
// config    in         cfg_we_i                  cfg_wdata_i (sweep_up_first)
//
// Sequencing: a load sorts the new request into the store by insertion, with
// one RAM read and one write per shifted (larger) entry; an empty store takes
// just the write. A run over n requests first scans the sorted entries for the
// split point (at most n entries scanned) and then emits one result per RAM
// read; every step is paced by the single registered RAM read port. A run on an
// empty store and a load into a full store are handled in idle and never raise busy.
// Reset clears the request count, the drop flag and sets sweep_up_first; the
// RAM is not cleared, only counted entries are ever read.
// The receiver cannot stall: each result is shown for one cycle only.

module look_disk_scheduler #(
  parameter int unsigned MAX_REQUESTS = lds_pkg::MAX_REQUESTS_DEF,
  parameter int unsigned TRACK_BITS   = lds_pkg::TRACK_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire lds_pkg::req_t req_i,
  output logic               res_strobe_o,
  output lds_pkg::res_t      res_o,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i
);

  // stored tracks are masked to TRACK_BITS, never wider than the field
  localparam int unsigned StoreW = (TRACK_BITS < lds_pkg::FIELD_W) ? TRACK_BITS
                                                                    : lds_pkg::FIELD_W;
  localparam int unsigned AddrW  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned CntW   = $clog2(MAX_REQUESTS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_REQUESTS);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_INS_FIN = 3'd3;
  localparam logic [2:0] S_SPL_RD  = 3'd4;
  localparam logic [2:0] S_SPL_CMP = 3'd5;
  localparam logic [2:0] S_EMT_RD  = 3'd6;
  localparam logic [2:0] S_EMT_CMP = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;       // queued requests
  logic              drop_q, drop_d;     // a load was dropped since last run
  logic              sweep_q;            // sweep_up_first register
  logic [CntW-1:0]   up_q, up_d;         // insert slot, scan index, next upward index
  logic [CntW-1:0]   dn_q, dn_d;         // one above the next downward index
  logic              dir_q, dir_d;       // current sweep direction, 1 = up
  logic [CntW-1:0]   k_q, k_d;           // results emitted in this run
  logic [StoreW-1:0] opnd_q, opnd_d;     // value to insert, head, then current track
  logic [lds_pkg::MOVE_W-1:0] move_q, move_d;
  logic              strobe_d;
  lds_pkg::res_t     res_d;

  logic              accept;
  logic [StoreW-1:0] in_track;

  logic              ram_we;
  logic [CntW-1:0]   ram_wsel;
  logic [StoreW-1:0] ram_wdata;
  logic [CntW-1:0]   ram_rsel;
  logic [StoreW-1:0] ram_rdata;

  lds_pkg::cmp_flags_t cmp_flags;
  logic [StoreW-1:0]   cmp_absdiff;

  logic              up_avail, dn_avail, take_up;
  logic [CntW-1:0]   emit_sel;
  logic [lds_pkg::MOVE_W:0] move_sum;
  logic              is_last;

  assign accept   = start && !busy;
  assign in_track = req_i.track[StoreW-1:0];
  assign busy     = (state_q != S_IDLE);

  lds_ram #(
    .WIDTH (StoreW),
    .DEPTH (MAX_REQUESTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wsel[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_rsel[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // the RAM word is always the left operand; the right one is the held operand
  lds_cmp #(
    .W (StoreW)
  ) u_cmp (
    .a_i       (ram_rdata),
    .b_i       (opnd_q),
    .flags_o   (cmp_flags),
    .absdiff_o (cmp_absdiff)
  );

  // pick the next index of the sweep; turn around when one side runs out
  assign up_avail = (up_q != cnt_q);
  assign dn_avail = (dn_q != '0);
  assign take_up  = dir_q ? up_avail : !dn_avail;
  assign emit_sel = take_up ? up_q : (dn_q - CntOne);

  assign move_sum = {1'b0, move_q} + (lds_pkg::MOVE_W + 1)'(cmp_absdiff);
  assign is_last  = ((k_q + CntOne) == cnt_q);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    drop_d   = drop_q;
    up_d     = up_q;
    dn_d     = dn_q;
    dir_d    = dir_q;
    k_d      = k_q;
    opnd_d   = opnd_q;
    move_d   = move_q;
    strobe_d = 1'b0;
    res_d    = res_o;
    ram_we   = 1'b0;
    ram_wsel = up_q;
    ram_wdata = opnd_q;
    ram_rsel = up_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          opnd_d = in_track;
          if (req_i.cmd == lds_pkg::CMD_LOAD) begin
            if (cnt_q == CntMax) begin
              // store full: drop the request
              drop_d = 1'b1;
            end else begin
              up_d    = cnt_q;
              state_d = (cnt_q == '0) ? S_INS_FIN : S_INS_RD;
            end
          end else if (cnt_q == '0) begin
            // empty run: one flagged result with the head itself
            strobe_d                 = 1'b1;
            res_d.served_track       = lds_pkg::FIELD_W'(in_track);
            res_d.total_movement     = '0;
            res_d.last               = 1'b1;
            res_d.empty_run          = 1'b1;
            res_d.overflow           = drop_q;
            drop_d                   = 1'b0;
          end else begin
            up_d    = '0;
            state_d = S_SPL_RD;
          end
        end
      end

      S_INS_RD: begin
        ram_rsel = up_q - CntOne;
        state_d  = S_INS_CMP;
      end

      S_INS_CMP: begin
        ram_we = 1'b1;
        if (cmp_flags.gt) begin
          // shift the larger entry up one slot
          ram_wdata = ram_rdata;
          up_d      = up_q - CntOne;
          state_d   = (up_q == CntOne) ? S_INS_FIN : S_INS_RD;
        end else begin
          cnt_d   = cnt_q + CntOne;
          state_d = S_IDLE;
        end
      end

      S_INS_FIN: begin
        ram_we  = 1'b1;
        cnt_d   = cnt_q + CntOne;
        state_d = S_IDLE;
      end

      S_SPL_RD: begin
        state_d = S_SPL_CMP;
      end

      S_SPL_CMP: begin
        dir_d  = sweep_q;
        k_d    = '0;
        move_d = '0;
        if (cmp_flags.ge) begin
          dn_d    = up_q;
          state_d = S_EMT_RD;
        end else begin
          up_d    = up_q + CntOne;
          dn_d    = up_q + CntOne;
          state_d = ((up_q + CntOne) == cnt_q) ? S_EMT_RD : S_SPL_RD;
        end
      end

      S_EMT_RD: begin
        ram_rsel = emit_sel;
        dir_d    = take_up;
        if (take_up) begin
          up_d = up_q + CntOne;
        end else begin
          dn_d = dn_q - CntOne;
        end
        state_d = S_EMT_CMP;
      end

      S_EMT_CMP: begin
        move_d = move_sum[lds_pkg::MOVE_W] ? lds_pkg::MOVE_MAX
                                           : move_sum[lds_pkg::MOVE_W-1:0];
        strobe_d             = 1'b1;
        res_d.served_track   = lds_pkg::FIELD_W'(ram_rdata);
        res_d.total_movement = move_d;
        res_d.last           = is_last;
        res_d.empty_run      = 1'b0;
        res_d.overflow       = drop_q;
        opnd_d               = ram_rdata;
        k_d                  = k_q + CntOne;
        if (is_last) begin
          cnt_d   = '0;
          drop_d  = 1'b0;
          state_d = S_IDLE;
        end else begin
          state_d = S_EMT_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      drop_q       <= 1'b0;
      sweep_q      <= 1'b1;
      res_strobe_o <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      drop_q       <= drop_d;
      res_strobe_o <= strobe_d;
      if (cfg_we_i) begin
        sweep_q <= cfg_wdata_i;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    up_q   <= up_d;
    dn_q   <= dn_d;
    dir_q  <= dir_d;
    k_q    <= k_d;
    opnd_q <= opnd_d;
    move_q <= move_d;
    res_o  <= res_d;
  end

  // the request count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("request count beyond store depth");

  // a run on an empty store answers in the next cycle with a flagged result
  a_empty_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.cmd == lds_pkg::CMD_RUN && cnt_q == '0)
      |=> (res_strobe_o && res_o.empty_run && res_o.last))
    else $error("empty run did not give its flagged result");

  // an empty-run result carries no movement
  a_empty_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.empty_run) |-> (res_o.total_movement == '0))
    else $error("empty run reported movement");

  // after the last result of a sweep the block is idle with an empty store
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.last && !res_o.empty_run) |-> (!busy && cnt_q == '0))
    else $error("sequencer still busy after last result");

endmodule

`default_nettype wire

[test/look_disk_scheduler_tb.sv]
// Self-checking testbench for the LOOK disk scheduler (look_disk_scheduler).
// Depends on lds_pkg and the scheduler RTL; holds its own model of the sweep order
// and compares every result transfer with it.

module look_disk_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REQ = lds_pkg::MAX_REQUESTS_DEF;
  localparam int SETTLE_CYCLES = 80;  // wait after the block is idle, longer than the longest run over a full store

  // Tracks the pending requests and the sweep direction, and keeps the service
  // order that each run transfer is due to produce.
  class sweep_board;
    lds_pkg::res_t service_order[$];
    logic [15:0] queued_tracks[$];
    bit dropped;
    bit up_first;
    int errors;
    int requests;
    int drops;
    int sweeps;
    int empty_sweeps;
    int services;

    function new();
      up_first = 1'b1;
    endfunction

    function void set_sweep(bit v);
      up_first = v;
    endfunction

    function void note_request(lds_pkg::req_t r);
      logic [15:0] sorted [MAX_REQ];
      logic [15:0] order [MAX_REQ];
      logic [15:0] v;
      logic [15:0] cur;
      int n;
      int split;
      int len;
      int i;
      int j;
      int unsigned moved;
      lds_pkg::res_t res;
      if (r.cmd == lds_pkg::CMD_LOAD) begin
        requests++;
        if (queued_tracks.size() < MAX_REQ) begin
          queued_tracks.push_back(r.track);
        end else begin
          dropped = 1'b1;
          drops++;
        end
        return;
      end
      sweeps++;
      n = queued_tracks.size();
      if (n == 0) begin
        // nothing queued: report the head itself
        res.served_track   = r.track;
        res.total_movement = '0;
        res.last           = 1'b1;
        res.empty_run      = 1'b1;
        res.overflow       = dropped;
        service_order.push_back(res);
        empty_sweeps++;
      end else begin
        for (i = 0; i < n; i++) begin
          v = queued_tracks[i];
          j = i;
          while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
          end
          sorted[j] = v;
        end
        // split at the first request at or above the head
        split = n;
        for (i = n - 1; i >= 0; i--) begin
          if (sorted[i] >= r.track) split = i;
        end
        len = 0;
        if (up_first) begin
          for (i = split; i < n; i++) begin
            order[len] = sorted[i];
            len++;
          end
          for (i = split - 1; i >= 0; i--) begin
            order[len] = sorted[i];
            len++;
          end
        end else begin
          for (i = split - 1; i >= 0; i--) begin
            order[len] = sorted[i];
            len++;
          end
          for (i = split; i < n; i++) begin
            order[len] = sorted[i];
            len++;
          end
        end
        cur = r.track;
        moved = 0;
        for (i = 0; i < len; i++) begin
          moved += (order[i] >= cur) ? (order[i] - cur) : (cur - order[i]);
          if (moved > lds_pkg::MOVE_MAX) moved = lds_pkg::MOVE_MAX;
          cur = order[i];
          res.served_track   = order[i];
          res.total_movement = moved[16:0];
          res.last           = (i == len - 1);
          res.empty_run      = 1'b0;
          res.overflow       = dropped;
          service_order.push_back(res);
        end
      end
      queued_tracks.delete();
      dropped = 1'b0;
    endfunction

    function void check_service(lds_pkg::res_t got);
      lds_pkg::res_t want;
      if (service_order.size() == 0) begin
        $error("result transfer with nothing pending: served_track %0d", got.served_track);
        errors++;
        return;
      end
      want = service_order.pop_front();
      services++;
      if (got.served_track !== want.served_track) begin
        $error("served_track: expected %0d, got %0d", want.served_track, got.served_track);
        errors++;
      end
      if (got.total_movement !== want.total_movement) begin
        $error("total_movement: expected %0d, got %0d", want.total_movement,
               got.total_movement);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
      if (got.empty_run !== want.empty_run) begin
        $error("empty_run: expected %0d, got %0d", want.empty_run, got.empty_run);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  lds_pkg::req_t req_i = '0;
  logic          res_strobe_o;
  lds_pkg::res_t res_o;
  logic          cfg_we_i = 1'b0;
  logic          cfg_wdata_i = 1'b0;

  sweep_board board = new();
  int burst_left = 0;
  int accepted_items = 0;

  look_disk_scheduler uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 0;
  end

  // Results cannot be held off: sample every strobe at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) board.check_service(res_o);
  end

  // Hand one command to the block. The sender works in bursts; between bursts
  // start may drop for a random gap. Leave start high after the transfer so that
  // the next item of a burst follows without a bubble.
  task automatic send(logic cmd_bit, logic [15:0] trk);
    int gap;
    lds_pkg::req_t item;
    item.cmd   = cmd_bit;
    item.track = trk;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    req_i <= item;
    // transfer happens at the first edge that sees start high and busy low
    do @(posedge clk_i); while (busy);
    board.note_request(item);
    accepted_items++;
  endtask

  // Drop start, wait for every pending result, then let a load still being
  // sorted into the store finish before anything else is touched.
  task automatic settle();
    start <= 1'b0;
    while (board.service_order.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sweep(bit up);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= up;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_sweep(up);
  endtask

  // Track values by style: clustered near a base (duplicates, ties with the
  // head), the two ends of the disk, or anywhere.
  function automatic logic [15:0] pick_track(int style, logic [15:0] base);
    case (style)
      0: return 16'(base + $urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'hFFFF;
          default: return 16'($urandom);
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly a well-formed batch: a run of loads, then a run command. The rest
  // is noise: a stray run, or loads left behind for the next sweep.
  task automatic random_batch(bit force_overflow);
    int loads;
    int style;
    int i;
    logic [15:0] base;
    logic [15:0] head;
    logic [15:0] t;
    logic [15:0] loaded[$];
    style = $urandom_range(0, 3);
    base  = 16'($urandom);
    if (force_overflow) begin
      loads = $urandom_range(MAX_REQ + 1, MAX_REQ + 4);
    end else begin
      case ($urandom_range(0, 9))
        0: loads = 0;
        1: loads = MAX_REQ;
        2: loads = $urandom_range(MAX_REQ + 1, MAX_REQ + 3);
        default: loads = $urandom_range(1, 8);
      endcase
    end
    if (force_overflow || $urandom_range(0, 9) < 8) begin
      for (i = 0; i < loads; i++) begin
        t = pick_track(style, base);
        loaded.push_back(t);
        send(lds_pkg::CMD_LOAD, t);
      end
      case ($urandom_range(0, 4))
        0: head = 16'h0000;
        1: head = 16'hFFFF;
        2: head = (loaded.size() != 0) ? loaded[$urandom_range(0, loaded.size() - 1)] : base;
        default: head = pick_track(style, base);
      endcase
      send(lds_pkg::CMD_RUN, head);
    end else if ($urandom_range(0, 1) == 1) begin
      send(lds_pkg::CMD_RUN, 16'($urandom));
    end else begin
      loads = $urandom_range(1, 4);
      for (i = 0; i < loads; i++) send(lds_pkg::CMD_LOAD, 16'($urandom));
    end
  endtask

  initial begin
    int phase;
    int target;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, higher tracks first.
    write_sweep(1'b1);
    send(lds_pkg::CMD_RUN, 16'h0000);   // empty store, head at the bottom
    send(lds_pkg::CMD_RUN, 16'hFFFF);   // empty store, head at the top
    send(lds_pkg::CMD_LOAD, 16'h0000);
    send(lds_pkg::CMD_LOAD, 16'hFFFF);
    send(lds_pkg::CMD_LOAD, 16'h8000);
    send(lds_pkg::CMD_LOAD, 16'h8000);  // duplicate request
    send(lds_pkg::CMD_LOAD, 16'h7FFF);
    send(lds_pkg::CMD_RUN, 16'h8000);   // head sits on a request: it joins the upper side
    send(lds_pkg::CMD_LOAD, 16'h0001);
    send(lds_pkg::CMD_LOAD, 16'h0002);
    send(lds_pkg::CMD_RUN, 16'h0000);   // nothing below the head
    send(lds_pkg::CMD_LOAD, 16'h0010);
    send(lds_pkg::CMD_LOAD, 16'h0020);
    send(lds_pkg::CMD_RUN, 16'hFFFF);   // nothing above the head
    settle();

    // Directed, lower tracks first.
    write_sweep(1'b0);
    send(lds_pkg::CMD_LOAD, 16'h0000);
    send(lds_pkg::CMD_LOAD, 16'hFFFF);
    send(lds_pkg::CMD_LOAD, 16'h0100);
    send(lds_pkg::CMD_RUN, 16'h0100);
    send(lds_pkg::CMD_LOAD, 16'hAAAA);
    send(lds_pkg::CMD_LOAD, 16'h5555);
    send(lds_pkg::CMD_RUN, 16'h0000);
    settle();

    // Random phases, alternating the sweep direction; each opens with an
    // overfilled store so dropped loads show up in every phase.
    for (phase = 0; phase < 4; phase++) begin
      write_sweep(phase[0]);
      target = accepted_items + 44;
      random_batch(1'b1);
      while (accepted_items < target) random_batch(1'b0);
      settle();
    end

    if (board.service_order.size() != 0) begin
      $error("%0d expected results never arrived", board.service_order.size());
      board.errors++;
    end
    $display("tb: %0d loads (%0d dropped) and %0d runs (%0d on an empty store)",
             board.requests, board.drops, board.sweeps, board.empty_sweeps);
    $display("tb: %0d serviced tracks checked over both sweep directions", board.services);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #1ms;
    $display("tb: failure");
    $finish;
  end

endmodule
